### sv/blsc_pkg.sv
// Shared types and constants for the battery load switch controller.
// No dependencies; every other file of the block depends on this package.
package blsc_pkg;

  // Field widths.
  localparam int unsigned CmdW = 3;
  localparam int unsigned PctW = 7;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 7;

  // Register reset values.
  localparam logic [PctW-1:0] OnThrRst = 7'd30;
  localparam logic [PctW-1:0] OffThrRst = 7'd80;
  localparam logic [PctW-1:0] StorageRst = 7'd40;
  localparam logic [PctW-1:0] LowRst = 7'd35;
  localparam logic [PctW-1:0] CriticalRst = 7'd20;
  localparam logic [PctW-1:0] PrevPctRst = 7'd100;

  // Command codes of an input word.
  typedef enum logic [CmdW-1:0] {
    CmdReport  = 3'd0,
    CmdOff     = 3'd1,
    CmdOn      = 3'd2,
    CmdToggle  = 3'd3,
    CmdReapply = 3'd4
  } blsc_cmd_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    RegAutoOnEn  = 3'd0,
    RegAutoOffEn = 3'd1,
    RegOnThr     = 3'd2,
    RegOffThr    = 3'd3,
    RegStorage   = 3'd4,
    RegLow       = 3'd5,
    RegCritical  = 3'd6
  } blsc_reg_e;

  // Configuration register file contents.
  typedef struct packed {
    logic            auto_on_en;
    logic            auto_off_en;
    logic [PctW-1:0] on_thr;
    logic [PctW-1:0] off_thr;
    logic [PctW-1:0] storage_lvl;
    logic [PctW-1:0] low_lvl;
    logic [PctW-1:0] crit_lvl;
  } blsc_cfg_t;

  // Persistent controller state.
  typedef struct packed {
    logic            switch_on;
    logic [PctW-1:0] prev_pct;
  } blsc_state_t;

  // One result word.
  typedef struct packed {
    logic switch_on;
    logic switch_written;
    logic low_warning;
    logic critical_warning;
    logic bad_command;
  } blsc_res_t;

endpackage

### sv/blsc_if.sv
// Valid/ready channel interfaces for the input and result words.
// Depends on blsc_pkg for the field widths.
interface blsc_in_if;
  logic                         valid;
  logic                         ready;
  logic [blsc_pkg::CmdW-1:0]    command;
  logic [blsc_pkg::PctW-1:0]    battery_percent;

  modport source (output valid, output command, output battery_percent, input ready);
  modport sink (input valid, input command, input battery_percent, output ready);
endinterface

interface blsc_out_if;
  logic valid;
  logic ready;
  logic switch_on;
  logic switch_written;
  logic low_warning;
  logic critical_warning;
  logic bad_command;

  modport source (output valid, output switch_on, output switch_written,
                  output low_warning, output critical_warning, output bad_command,
                  input ready);
  modport sink (input valid, input switch_on, input switch_written,
                input low_warning, input critical_warning, input bad_command,
                output ready);
endinterface

### sv/battery_load_switch_controller.sv
// Battery load switch controller: top level with config registers, pipeline and state.
// Depends on blsc_pkg, blsc_if and blsc_rules.

// Every input word gives exactly one result word. A word is captured in an input
// register, evaluated combinationally against the switch state and the configuration,
// and lands in a result register whenever that register is empty or its result is
// taken in the same cycle. One word is accepted per cycle while the result side does
// not stall. The user writes configuration through cfg_we_i/cfg_idx_i/cfg_data_i only
// while the block is idle; the block itself does not enforce this. An index of seven
// or above is ignored.
module battery_load_switch_controller (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  blsc_in_if.sink                       in_i,
  blsc_out_if.source                    out_o,
  input  logic                          cfg_we_i,
  input  logic [blsc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [blsc_pkg::CfgDataW-1:0] cfg_data_i
);
  import blsc_pkg::*;

  blsc_cfg_t       cfg_q;
  blsc_state_t     state_q, state_d;
  logic            in_vld_q;
  logic [CmdW-1:0] in_cmd_q;
  logic [PctW-1:0] in_pct_q;
  logic            out_vld_q;
  blsc_res_t       out_res_q, res_d;
  logic            out_free;
  logic            advance;
  logic            in_take;

  // Handshake: the result stage frees up when empty or being taken.
  assign out_free = !out_vld_q || out_o.ready;
  assign advance  = in_vld_q && out_free;
  assign in_i.ready = !in_vld_q || advance;
  assign in_take  = in_i.valid && in_i.ready;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.auto_on_en  <= 1'b1;
      cfg_q.auto_off_en <= 1'b1;
      cfg_q.on_thr      <= OnThrRst;
      cfg_q.off_thr     <= OffThrRst;
      cfg_q.storage_lvl <= StorageRst;
      cfg_q.low_lvl     <= LowRst;
      cfg_q.crit_lvl    <= CriticalRst;
    end else if (cfg_we_i) begin
      case (blsc_reg_e'(cfg_idx_i))
        RegAutoOnEn:  cfg_q.auto_on_en  <= cfg_data_i[0];
        RegAutoOffEn: cfg_q.auto_off_en <= cfg_data_i[0];
        RegOnThr:     cfg_q.on_thr      <= cfg_data_i[PctW-1:0];
        RegOffThr:    cfg_q.off_thr     <= cfg_data_i[PctW-1:0];
        RegStorage:   cfg_q.storage_lvl <= cfg_data_i[PctW-1:0];
        RegLow:       cfg_q.low_lvl     <= cfg_data_i[PctW-1:0];
        RegCritical:  cfg_q.crit_lvl    <= cfg_data_i[PctW-1:0];
        default:      cfg_q <= cfg_q;
      endcase
    end
  end

  // Input register: valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  // Input register: payload.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_cmd_q <= in_i.command;
      in_pct_q <= in_i.battery_percent;
    end
  end

  // Rule evaluation for the word in the input register.
  blsc_rules u_rules (
    .cmd_i   (in_cmd_q),
    .pct_i   (in_pct_q),
    .cfg_i   (cfg_q),
    .state_i (state_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  // Switch state and last percent update as a word moves to the result stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.switch_on <= 1'b0;
      state_q.prev_pct  <= PrevPctRst;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register: valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q;
    end
  end

  // Result register: payload.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= res_d;
    end
  end

  assign out_o.valid            = out_vld_q;
  assign out_o.switch_on        = out_res_q.switch_on;
  assign out_o.switch_written   = out_res_q.switch_written;
  assign out_o.low_warning      = out_res_q.low_warning;
  assign out_o.critical_warning = out_res_q.critical_warning;
  assign out_o.bad_command      = out_res_q.bad_command;

endmodule

### sv/blsc_rules.sv
// Combinational rule evaluation for one word: next switch state and result.
// Depends on blsc_pkg for the command codes and the state, config and result types.
module blsc_rules (
  input  logic [blsc_pkg::CmdW-1:0] cmd_i,
  input  logic [blsc_pkg::PctW-1:0] pct_i,
  input  blsc_pkg::blsc_cfg_t       cfg_i,
  input  blsc_pkg::blsc_state_t     state_i,
  output blsc_pkg::blsc_state_t     state_o,
  output blsc_pkg::blsc_res_t       res_o
);
  import blsc_pkg::*;

  logic            sw;
  logic            wr;
  logic [PctW-1:0] pct_sel;

  always_comb begin
    sw = state_i.switch_on;
    wr = 1'b0;
    state_o = state_i;
    res_o = '0;
    // A report works on its own percent; reapply works on the stored one.
    pct_sel = (cmd_i == CmdReport) ? pct_i : state_i.prev_pct;

    case (blsc_cmd_e'(cmd_i))
      CmdReport, CmdReapply: begin
        // Auto rules drive the switch only when they change it.
        if (cfg_i.auto_on_en && (pct_sel < cfg_i.on_thr) && !sw) begin
          sw = 1'b1;
          wr = 1'b1;
        end
        if (cfg_i.auto_off_en && (pct_sel > cfg_i.off_thr) && sw) begin
          sw = 1'b0;
          wr = 1'b1;
        end
        if (cmd_i == CmdReport) begin
          // Storage level forces the switch off.
          if ((pct_i <= cfg_i.storage_lvl) && sw) begin
            sw = 1'b0;
            wr = 1'b1;
          end
          // Warnings fire on the crossing from above.
          res_o.low_warning = (pct_i <= cfg_i.low_lvl) && (pct_i > cfg_i.crit_lvl) &&
                              (state_i.prev_pct > cfg_i.low_lvl);
          if (pct_i <= cfg_i.crit_lvl) begin
            res_o.critical_warning = state_i.prev_pct > cfg_i.crit_lvl;
            if (sw) begin
              sw = 1'b0;
              wr = 1'b1;
            end
          end
          state_o.prev_pct = pct_i;
        end
      end
      CmdOff: begin
        sw = 1'b0;
        wr = 1'b1;
      end
      CmdOn: begin
        sw = 1'b1;
        wr = 1'b1;
      end
      CmdToggle: begin
        sw = ~sw;
        wr = 1'b1;
      end
      default: begin
        res_o.bad_command = 1'b1;
      end
    endcase

    state_o.switch_on = sw;
    res_o.switch_on = sw;
    res_o.switch_written = wr;
  end

endmodule

### dv/blsc_switch_checker.sv
// Checker for the battery load switch controller: predicts every result word and compares it.
// Depends on blsc_pkg for types and codes and on blsc_if for the channel interfaces.
module blsc_switch_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  blsc_in_if                            word_i,
  blsc_out_if                           result_i,
  input  logic                          cfg_we_i,
  input  logic [blsc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [blsc_pkg::CfgDataW-1:0] cfg_data_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o
);
  import blsc_pkg::*;

  // Shadow copies of the register file and of the switch state.
  blsc_cfg_t   cfg_q;
  blsc_state_t sw_q;

  // Result words predicted but not yet seen on the output channel.
  blsc_res_t   switch_results_q[$];

  int unsigned n_errors = 0;
  int unsigned n_results = 0;

  assign fail_count_o = n_errors;

  // Prints one line per mismatch and counts it.
  task automatic report_error(input string msg);
    $display("[%0t] ERROR %s", $time, msg);
    n_errors++;
  endtask

  // Auto-on and auto-off on a given percent; returns whether the switch was driven.
  function automatic logic run_auto_switching(input logic [PctW-1:0] pct);
    logic driven;
    driven = 1'b0;
    if (cfg_q.auto_on_en && pct < cfg_q.on_thr && !sw_q.switch_on) begin
      sw_q.switch_on = 1'b1;
      driven = 1'b1;
    end
    if (cfg_q.auto_off_en && pct > cfg_q.off_thr && sw_q.switch_on) begin
      sw_q.switch_on = 1'b0;
      driven = 1'b1;
    end
    return driven;
  endfunction

  // Works out the result word of one input word and advances the switch state.
  function automatic blsc_res_t next_switch_result(input logic [CmdW-1:0] cmd,
                                                   input logic [PctW-1:0] pct);
    blsc_res_t r;
    r = '0;
    case (cmd)
      CmdReport: begin
        r.switch_written = run_auto_switching(pct);
        // Storage level always wins over auto-on.
        if (pct <= cfg_q.storage_lvl && sw_q.switch_on) begin
          sw_q.switch_on = 1'b0;
          r.switch_written = 1'b1;
        end
        // Low warning only on the way into the band from above.
        if (pct <= cfg_q.low_lvl && pct > cfg_q.crit_lvl && sw_q.prev_pct > cfg_q.low_lvl) begin
          r.low_warning = 1'b1;
        end
        if (pct <= cfg_q.crit_lvl) begin
          if (sw_q.prev_pct > cfg_q.crit_lvl) begin
            r.critical_warning = 1'b1;
          end
          if (sw_q.switch_on) begin
            sw_q.switch_on = 1'b0;
            r.switch_written = 1'b1;
          end
        end
        sw_q.prev_pct = pct;
      end
      CmdOff: begin
        sw_q.switch_on = 1'b0;
        r.switch_written = 1'b1;
      end
      CmdOn: begin
        sw_q.switch_on = 1'b1;
        r.switch_written = 1'b1;
      end
      CmdToggle: begin
        sw_q.switch_on = !sw_q.switch_on;
        r.switch_written = 1'b1;
      end
      CmdReapply: begin
        r.switch_written = run_auto_switching(sw_q.prev_pct);
      end
      default: begin
        r.bad_command = 1'b1;
      end
    endcase
    r.switch_on = sw_q.switch_on;
    return r;
  endfunction

  // Tracks register writes, predicts accepted words and checks accepted results.
  always @(posedge clk_i or negedge rst_ni) begin
    blsc_res_t got;
    blsc_res_t want;
    if (!rst_ni) begin
      cfg_q.auto_on_en  = 1'b1;
      cfg_q.auto_off_en = 1'b1;
      cfg_q.on_thr      = OnThrRst;
      cfg_q.off_thr     = OffThrRst;
      cfg_q.storage_lvl = StorageRst;
      cfg_q.low_lvl     = LowRst;
      cfg_q.crit_lvl    = CriticalRst;
      sw_q.switch_on    = 1'b0;
      sw_q.prev_pct     = PrevPctRst;
      switch_results_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegAutoOnEn:  cfg_q.auto_on_en = cfg_data_i[0];
          RegAutoOffEn: cfg_q.auto_off_en = cfg_data_i[0];
          RegOnThr:     cfg_q.on_thr = cfg_data_i[PctW-1:0];
          RegOffThr:    cfg_q.off_thr = cfg_data_i[PctW-1:0];
          RegStorage:   cfg_q.storage_lvl = cfg_data_i[PctW-1:0];
          RegLow:       cfg_q.low_lvl = cfg_data_i[PctW-1:0];
          RegCritical:  cfg_q.crit_lvl = cfg_data_i[PctW-1:0];
          default: ;
        endcase
      end

      if (word_i.valid && word_i.ready) begin
        switch_results_q.push_back(next_switch_result(word_i.command, word_i.battery_percent));
      end

      if (result_i.valid && result_i.ready) begin
        got.switch_on        = result_i.switch_on;
        got.switch_written   = result_i.switch_written;
        got.low_warning      = result_i.low_warning;
        got.critical_warning = result_i.critical_warning;
        got.bad_command      = result_i.bad_command;
        n_results++;
        if (switch_results_q.size() == 0) begin
          report_error($sformatf("result word %0d arrived with nothing expected", n_results));
        end else begin
          want = switch_results_q.pop_front();
          if (got.switch_on !== want.switch_on) begin
            report_error($sformatf("result word %0d switch_on: expected %0b got %0b",
                                   n_results, want.switch_on, got.switch_on));
          end
          if (got.switch_written !== want.switch_written) begin
            report_error($sformatf("result word %0d switch_written: expected %0b got %0b",
                                   n_results, want.switch_written, got.switch_written));
          end
          if (got.low_warning !== want.low_warning) begin
            report_error($sformatf("result word %0d low_warning: expected %0b got %0b",
                                   n_results, want.low_warning, got.low_warning));
          end
          if (got.critical_warning !== want.critical_warning) begin
            report_error($sformatf("result word %0d critical_warning: expected %0b got %0b",
                                   n_results, want.critical_warning, got.critical_warning));
          end
          if (got.bad_command !== want.bad_command) begin
            report_error($sformatf("result word %0d bad_command: expected %0b got %0b",
                                   n_results, want.bad_command, got.bad_command));
          end
        end
      end

      pending_o <= switch_results_q.size();
    end
  end

endmodule

### dv/tb_top.sv
// Testbench top for the battery load switch controller: clock, reset, stimulus and verdict.
// Depends on blsc_pkg, blsc_if, the block itself and blsc_switch_checker.
module tb_top;
  import blsc_pkg::*;

  // Codes that the block must reject.
  localparam logic [CmdW-1:0]    CmdInvalidFirst = 3'd5;
  localparam logic [CmdW-1:0]    CmdInvalidLast  = 3'd7;
  // A register index past the end of the register file.
  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;

  localparam int NumPhases     = 8;
  localparam int WordsPerPhase = 55;

  logic clk = 1'b0;
  logic rst_n;

  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  int unsigned fail_count;
  int unsigned pending;

  // Sender side: number of upcoming words offered without gaps.
  int unsigned tx_calm = 0;

  blsc_in_if  word_in ();
  blsc_out_if word_out ();

  battery_load_switch_controller uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (word_in),
    .out_o      (word_out),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  blsc_switch_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .word_i       (word_in),
    .result_i     (word_out),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Clock with a period of 10.
  always begin
    #5;
    clk = 1'b1;
    #5;
    clk = 1'b0;
  end

  // Hard limit on the run.
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  // Length of an idle gap: mostly none or short, sometimes long.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 20);
  endfunction

  // Result side: random stalls, calm stretches and a long hold-off now and then.
  initial begin
    int unsigned hold;
    int unsigned calm;
    int unsigned cycles;
    int unsigned next_long;
    hold = 0;
    calm = 0;
    cycles = 0;
    next_long = $urandom_range(100, 250);
    word_out.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold > 0) begin
        word_out.ready <= 1'b0;
        hold--;
      end else begin
        word_out.ready <= 1'b1;
        if (calm > 0) begin
          calm--;
        end else if ($urandom_range(0, 3) == 0) begin
          hold = idle_len();
        end else if ($urandom_range(0, 29) == 0) begin
          calm = $urandom_range(20, 60);
        end
      end
      // Long hold-off so that the block fills up and stalls its input.
      cycles++;
      if (cycles >= next_long) begin
        hold = $urandom_range(40, 80);
        cycles = 0;
        next_long = $urandom_range(150, 400);
      end
      @(posedge clk);
    end
  end

  // Offers one word after a random gap and returns at the edge that accepts it.
  task automatic send_word(input logic [CmdW-1:0] cmd, input logic [PctW-1:0] pct);
    int unsigned gap;
    if (tx_calm > 0) begin
      tx_calm--;
      gap = 0;
    end else begin
      gap = idle_len();
      if ($urandom_range(0, 29) == 0) begin
        tx_calm = $urandom_range(15, 40);
      end
    end
    if (gap != 0) begin
      word_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    word_in.valid           <= 1'b1;
    word_in.command         <= cmd;
    word_in.battery_percent <= pct;
    do @(posedge clk); while (word_in.ready !== 1'b1);
  endtask

  // Stops offering and waits until every predicted result has been taken.
  task automatic drain_results();
    int unsigned n;
    n = 0;
    word_in.valid <= 1'b0;
    do begin
      @(posedge clk);
      n++;
    end while (pending != 0 && n < 5000);
    repeat (4) @(posedge clk);
  endtask

  // Puts one register write on the port; the caller lowers the write enable.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  // Main stimulus.
  initial begin
    blsc_cfg_t cfg;
    int        level;
    int unsigned r;
    word_in.valid           <= 1'b0;
    word_in.command         <= '0;
    word_in.battery_percent <= '0;
    cfg_we   <= 1'b0;
    cfg_idx  <= '0;
    cfg_data <= '0;
    rst_n    <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words under the reset settings.
    send_word(CmdReport, 7'd100);
    send_word(CmdReport, 7'd127);   // above 100, compared as is
    send_word(CmdReport, 7'd33);    // enters the low band
    send_word(CmdReport, 7'd25);    // auto-on, then storage forces off
    send_word(CmdReport, 7'd20);    // reaches critical from above
    send_word(CmdReport, 7'd0);     // stays critical, no new warning
    send_word(CmdOn, 7'd0);
    send_word(CmdOn, 7'd127);       // already on, still driven
    send_word(CmdOff, 7'd0);
    send_word(CmdOff, 7'd64);       // already off, still driven
    send_word(CmdToggle, 7'd0);
    send_word(CmdToggle, 7'd0);
    send_word(CmdReapply, 7'd99);   // last percent is low: auto-on
    send_word(CmdReapply, 7'd0);    // nothing left to change
    send_word(CmdReport, 7'd90);    // auto-off
    send_word(CmdReapply, 7'd0);
    send_word(CmdOn, 7'd0);
    send_word(CmdReapply, 7'd0);    // auto-off from the last percent
    for (int c = CmdInvalidFirst; c <= CmdInvalidLast; c++) begin
      send_word(CmdW'(c), 7'd127);
    end
    send_word(CmdReport, 7'd50);
    send_word(CmdReport, 7'd36);    // just above the low band
    send_word(CmdReport, 7'd35);    // upper edge of the low band
    drain_results();

    // Random phases, each under its own register settings.
    level = 100;
    for (int p = 0; p < NumPhases; p++) begin
      cfg.auto_on_en  = 1'($urandom_range(0, 1));
      cfg.auto_off_en = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 2) != 0) begin
        // Ordered levels, as in normal use.
        cfg.crit_lvl    = PctW'($urandom_range(0, 30));
        cfg.low_lvl     = PctW'(cfg.crit_lvl + $urandom_range(0, 20));
        cfg.storage_lvl = PctW'(cfg.low_lvl + $urandom_range(0, 20));
        cfg.on_thr      = PctW'($urandom_range(0, 60));
        cfg.off_thr     = PctW'(cfg.on_thr + $urandom_range(0, 40));
      end else begin
        cfg.crit_lvl    = PctW'($urandom_range(0, 100));
        cfg.low_lvl     = PctW'($urandom_range(0, 100));
        cfg.storage_lvl = PctW'($urandom_range(0, 100));
        cfg.on_thr      = PctW'($urandom_range(0, 100));
        cfg.off_thr     = PctW'($urandom_range(0, 100));
      end
      // The first two phases pin the extremes; the next two pin the auto rules.
      if (p == 0) begin
        cfg.auto_on_en  = 1'b1;
        cfg.auto_off_en = 1'b1;
        cfg.crit_lvl    = '0;
        cfg.low_lvl     = '0;
        cfg.storage_lvl = '0;
        cfg.on_thr      = '0;
        cfg.off_thr     = '0;
      end else if (p == 1) begin
        cfg.auto_on_en  = 1'b1;
        cfg.auto_off_en = 1'b1;
        cfg.crit_lvl    = 7'd100;
        cfg.low_lvl     = 7'd100;
        cfg.storage_lvl = 7'd100;
        cfg.on_thr      = 7'd100;
        cfg.off_thr     = 7'd100;
      end else if (p == 2) begin
        cfg.auto_on_en  = 1'b0;
        cfg.auto_off_en = 1'b0;
      end else if (p == 3) begin
        // Auto rules on, protection levels out of the way.
        cfg.auto_on_en  = 1'b1;
        cfg.auto_off_en = 1'b1;
        cfg.crit_lvl    = '0;
        cfg.storage_lvl = '0;
      end

      // A write past the last register is ignored.
      write_reg(RegUnused, CfgDataW'($urandom));
      write_reg(RegAutoOnEn, CfgDataW'(cfg.auto_on_en));
      write_reg(RegAutoOffEn, CfgDataW'(cfg.auto_off_en));
      write_reg(RegOnThr, cfg.on_thr);
      write_reg(RegOffThr, cfg.off_thr);
      write_reg(RegStorage, cfg.storage_lvl);
      write_reg(RegLow, cfg.low_lvl);
      write_reg(RegCritical, cfg.crit_lvl);
      cfg_we <= 1'b0;

      for (int i = 0; i < WordsPerPhase; i++) begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          // A discharge curve with occasional recharges, so the bands are crossed.
          level = level + int'($urandom_range(0, 9)) - 7;
          if (level < 0 || $urandom_range(0, 11) == 0) begin
            level = $urandom_range(45, 127);
          end
          send_word(CmdReport, PctW'(level));
        end else if (r < 90) begin
          send_word(CmdW'(CmdOff + $urandom_range(0, 3)), PctW'($urandom));
        end else begin
          send_word(CmdW'($urandom_range(0, 7)), PctW'($urandom));
        end
      end
      drain_results();
    end

    if (pending != 0) begin
      $display("[%0t] ERROR %0d result words never arrived", $time, pending);
    end
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
